[rtl/core/isfc_pkg.sv]
// ============================================================================
// isfc_pkg
// Shared types and constants for the input-side FIR convolution block:
// item formats, opcodes and the control bundle sent along the tap cells.
// ============================================================================
package isfc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int IDX_BITS    = 6;
    localparam int CFG_BITS    = 7;

    localparam logic [CFG_BITS-1:0] ACTIVE_TAPS_RST = 7'd64;

    // Opcodes of an input item
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic                          opcode;
        logic [IDX_BITS-1:0]           tap_index;
        logic signed [SAMPLE_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_sample;
        logic                          clipped;
    } out_item_t;

    // Control bundle broadcast to every tap cell
    typedef struct packed {
        logic                          sample_en;
        logic                          coef_en;
        logic [IDX_BITS-1:0]           tap_index;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [CFG_BITS-1:0]           active_taps;
    } cell_ctl_t;

endpackage

[rtl/core/isfc_cell.sv]
// ============================================================================
// isfc_cell
// One tap of the transposed FIR chain: holds a coefficient and a partial sum,
// adds its product and hands the sum to the lower neighbor on each sample.
// ============================================================================
module isfc_cell #(
    parameter int ACC_BITS = 40,
    parameter int TAP_POS  = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  isfc_pkg::cell_ctl_t      ctl,
    input  logic [ACC_BITS-1:0]      sum_in,
    output logic [ACC_BITS-1:0]      sum_out
);

    localparam int PROD_BITS = 2 * isfc_pkg::SAMPLE_BITS;

    logic signed [isfc_pkg::SAMPLE_BITS-1:0] tap_reg;
    logic signed [isfc_pkg::SAMPLE_BITS-1:0] tap_next;
    logic [ACC_BITS-1:0]                     psum_reg;
    logic [ACC_BITS-1:0]                     psum_next;
    logic signed [PROD_BITS-1:0]             prod;
    logic signed [ACC_BITS-1:0]              prod_ext;
    logic                                    active;
    logic                                    hit;

    // Tap is in use when its position is below the active count
    assign active = {25'd0, ctl.active_taps} > 32'(TAP_POS);
    assign hit    = {26'd0, ctl.tap_index} == 32'(TAP_POS);

    // Multiply-accumulate toward the neighbor
    assign prod     = ctl.value * tap_reg;
    assign prod_ext = ACC_BITS'(prod);
    assign sum_out  = active ? psum_reg + prod_ext : psum_reg;

    // Load coefficient, shift partial sum on a sample
    always_comb begin
        tap_next  = (ctl.coef_en && hit) ? ctl.value : tap_reg;
        psum_next = ctl.sample_en ? sum_in : psum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg  <= '0;
            psum_reg <= '0;
        end else begin
            tap_reg  <= tap_next;
            psum_reg <= psum_next;
        end
    end

endmodule

[rtl/core/input_side_fir_convolution.sv]
// ============================================================================
// input_side_fir_convolution
// Transposed-form FIR: a chain of MAC cells, a result stage and an output
// register with rounding to Q1.15 and saturation.
// ============================================================================
// A sample's sum goes to the result stage, then to the output register.
// Throughput: 1 item per cycle while no blocked result stalls the input;
// all MAX_TAPS cells multiply-accumulate in parallel, so the rate is set
// by the single MAC in each cell. Coefficient writes give no result.
// Reset clears all taps and partial sums, sets active_taps to 64, empties
// the pipeline.
module input_side_fir_convolution #(
    parameter int MAX_TAPS = 64,
    parameter int ACC_BITS = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  isfc_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output isfc_pkg::out_item_t                 m_item,
    input  logic                                cfg_wr_en,
    input  logic [isfc_pkg::CFG_BITS-1:0]       cfg_wr_data
);

    localparam int SB = isfc_pkg::SAMPLE_BITS;
    localparam int FB = isfc_pkg::FRAC_BITS;
    localparam int QW = ACC_BITS + 1 - FB;
    localparam logic [ACC_BITS:0] RND_HALF = (ACC_BITS+1)'(1) << (FB - 1);

    logic [isfc_pkg::CFG_BITS-1:0] active_taps_reg;
    logic                          st1_valid_reg;
    logic [ACC_BITS-1:0]           st1_acc_reg;
    logic                          m_valid_reg;
    isfc_pkg::out_item_t           m_item_reg;

    isfc_pkg::cell_ctl_t           ctl;
    logic                          accept;
    logic                          out_load;
    logic                          st1_adv;
    logic [ACC_BITS-1:0]           chain [MAX_TAPS+1];

    logic [ACC_BITS:0]             rnd;
    logic signed [QW-1:0]          q;
    logic                          sat;
    isfc_pkg::out_item_t           m_item_next;

    // Handshake
    assign out_load = !m_valid_reg || m_ready;
    assign st1_adv  = st1_valid_reg && out_load;
    assign s_ready  = !st1_valid_reg || out_load;
    assign accept   = s_valid && s_ready;

    // Control bundle for the cells
    always_comb begin
        ctl.sample_en   = accept && (s_item.opcode == isfc_pkg::OP_SAMPLE);
        ctl.coef_en     = accept && (s_item.opcode == isfc_pkg::OP_COEF);
        ctl.tap_index   = s_item.tap_index;
        ctl.value       = s_item.value;
        ctl.active_taps = active_taps_reg;
    end

    // Chain of tap cells; a zero enters at the top
    assign chain[MAX_TAPS] = '0;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        isfc_cell #(
            .ACC_BITS (ACC_BITS),
            .TAP_POS  (j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .sum_in  (chain[j+1]),
            .sum_out (chain[j])
        );
    end

    // Round half up and saturate the finished sum
    always_comb begin
        rnd = {st1_acc_reg[ACC_BITS-1], st1_acc_reg} + RND_HALF;
        q   = rnd[ACC_BITS:FB];
        sat = !((&q[QW-1:SB-1]) || !(|q[QW-1:SB-1]));
        m_item_next.clipped = sat;
        if (sat) begin
            m_item_next.filtered_sample = q[QW-1] ? isfc_pkg::SAMPLE_MIN
                                                  : isfc_pkg::SAMPLE_MAX;
        end else begin
            m_item_next.filtered_sample = q[SB-1:0];
        end
    end

    // Hold config, result stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_taps_reg <= isfc_pkg::ACTIVE_TAPS_RST;
            st1_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                active_taps_reg <= cfg_wr_data;
            end
            if (ctl.sample_en) begin
                st1_valid_reg <= 1'b1;
            end else if (st1_adv) begin
                st1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sample_en) begin
            st1_acc_reg <= chain[0];
        end
        if (st1_adv) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[rtl/core/isfc_checker.sv]
// ============================================================================
// isfc_checker
// Port-level checks for the input-side FIR convolution block, bound to the
// top level.
// ============================================================================
module isfc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  isfc_pkg::out_item_t           m_item
);

    // Output empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // Input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // Clipped results sit at a rail
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.clipped |->
            (m_item.filtered_sample == isfc_pkg::SAMPLE_MAX) ||
            (m_item.filtered_sample == isfc_pkg::SAMPLE_MIN))
        else $error("clipped result not at a rail");

endmodule

bind input_side_fir_convolution isfc_checker u_isfc_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for input_side_fir_convolution. A behavioral model of
// the transposed FIR (tap store, partial-sum chain, round and saturate)
// predicts each output; a monitor compares every output item against the
// oldest prediction. Both handshakes idle at random, and the tap count is
// changed between phases, with its extremes included.
// ============================================================================
module tb;

    localparam int TAP_COUNT     = 64;
    localparam int ACC_W         = 40;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int MAX_REPORTS   = 50;
    localparam longint TIMEOUT_NS = 3_000_000;

    // Local widths taken from the package
    localparam int SMP_W = isfc_pkg::SAMPLE_BITS;
    localparam int IDX_W = isfc_pkg::IDX_BITS;
    localparam int CFG_W = isfc_pkg::CFG_BITS;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    isfc_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    isfc_pkg::out_item_t m_item;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;

    // Model state: tap store, partial-sum chain and the tap count in use
    logic signed [SMP_W-1:0]       tap_coefs [TAP_COUNT];
    logic signed [ACC_W-1:0]       partial_acc [TAP_COUNT];
    logic [CFG_W-1:0]              taps_in_use;
    isfc_pkg::out_item_t           expected_outputs [$];

    // Idling control: a steady side never waits
    bit tx_steady;
    bit rx_steady;

    int error_count;
    int items_sent;
    int n_samples;
    int n_coefs;
    int n_cfg;
    int n_results;
    int n_clipped;

    input_side_fir_convolution #(
        .MAX_TAPS (TAP_COUNT),
        .ACC_BITS (ACC_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d outputs still pending", expected_outputs.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Apply one accepted item to the model; a sample yields one expected output
    function automatic void predict_item(input isfc_pkg::in_item_t it);
        int                      n;
        logic signed [31:0]      prod;
        longint                  acc;
        longint                  q;
        logic                    clip;
        isfc_pkg::out_item_t     want;
        if (it.opcode == isfc_pkg::OP_COEF) begin
            tap_coefs[it.tap_index] = it.value;
            n_coefs++;
            return;
        end
        n_samples++;
        n = (taps_in_use > TAP_COUNT) ? TAP_COUNT : int'(taps_in_use);
        for (int j = 0; j < n; j++) begin
            prod = it.value * tap_coefs[j];
            partial_acc[j] = partial_acc[j] + prod;
        end
        // Round half up from the accumulator format, then saturate
        acc  = partial_acc[0];
        q    = (acc + (64'sd1 <<< (isfc_pkg::FRAC_BITS - 1))) >>> isfc_pkg::FRAC_BITS;
        clip = 1'b0;
        if (q > isfc_pkg::SAMPLE_MAX) begin
            q    = isfc_pkg::SAMPLE_MAX;
            clip = 1'b1;
        end else if (q < isfc_pkg::SAMPLE_MIN) begin
            q    = isfc_pkg::SAMPLE_MIN;
            clip = 1'b1;
        end
        want.filtered_sample = q[SMP_W-1:0];
        want.clipped         = clip;
        expected_outputs.push_back(want);
        // Advance the chain; a zero enters at the top
        for (int j = 0; j < TAP_COUNT - 1; j++) begin
            partial_acc[j] = partial_acc[j + 1];
        end
        partial_acc[TAP_COUNT-1] = '0;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic push_item(input isfc_pkg::in_item_t it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_item(it);
        items_sent++;
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] v);
        isfc_pkg::in_item_t it;
        it.opcode    = isfc_pkg::OP_SAMPLE;
        it.tap_index = IDX_W'($urandom);
        it.value     = v;
        push_item(it);
    endtask

    task automatic send_coef(input logic [IDX_W-1:0] idx,
                             input logic signed [SMP_W-1:0] v);
        isfc_pkg::in_item_t it;
        it.opcode    = isfc_pkg::OP_COEF;
        it.tap_index = idx;
        it.value     = v;
        push_item(it);
    endtask

    // Drop valid, let every output drain, then give the pipeline time to settle
    task automatic wait_idle();
        @(negedge aclk) s_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tap_count(input logic [CFG_W-1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        taps_in_use = v;
        n_cfg++;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    // Random level: narrow mostly stays within +/-1024, otherwise full range
    function automatic logic signed [SMP_W-1:0] rand_level(input bit narrow);
        if (narrow && $urandom_range(0, 4) != 0) begin
            return SMP_W'(int'($urandom_range(0, 2048)) - 1024);
        end
        case ($urandom_range(0, 7))
            0:       return isfc_pkg::SAMPLE_MAX;
            1:       return isfc_pkg::SAMPLE_MIN;
            2, 3:    return SMP_W'(int'($urandom_range(0, 512)) - 256);
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // Compare each output item with the oldest prediction
    initial begin : result_monitor
        int                  stall;
        isfc_pkg::out_item_t want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("output %0d/%0b with none expected",
                                          m_item.filtered_sample, m_item.clipped));
            end else begin
                want = expected_outputs.pop_front();
                if (m_item.filtered_sample !== want.filtered_sample) begin
                    report_mismatch($sformatf("output %0d: filtered_sample %0d, expected %0d",
                                              n_results, m_item.filtered_sample,
                                              want.filtered_sample));
                end
                if (m_item.clipped !== want.clipped) begin
                    report_mismatch($sformatf("output %0d: clipped %0b, expected %0b",
                                              n_results, m_item.clipped, want.clipped));
                end
                if (want.clipped) begin
                    n_clipped++;
                end
                n_results++;
            end
        end
    end

    // Cleared taps and default tap count: every output is zero
    task automatic test_reset_defaults();
        send_sample(isfc_pkg::SAMPLE_MAX);
        send_sample(isfc_pkg::SAMPLE_MIN);
        send_sample(16'sd0);
    endtask

    // Single taps at the field extremes, round-half-up and positive clipping
    task automatic test_impulse_and_rounding();
        send_coef(6'd0, 16'sd1);
        send_coef(6'd1, isfc_pkg::SAMPLE_MIN);
        send_coef(6'h3f, -16'sd1);
        send_coef(6'h15, 16'sh5555);
        send_coef(6'h2a, 16'shaaaa);
        send_sample(16'sd16384);
        send_sample(-16'sd16384);
        send_sample(isfc_pkg::SAMPLE_MIN);
        send_sample(isfc_pkg::SAMPLE_MAX);
        send_sample(-16'sd1);
        send_coef(6'd0, isfc_pkg::SAMPLE_MIN);
        send_sample(isfc_pkg::SAMPLE_MIN);
        send_sample(16'sd0);
        send_sample(16'sd0);
    endtask

    // No taps, one tap, the full count and values above it
    task automatic test_tap_count_edges();
        logic [CFG_W-1:0] counts [5];
        counts = '{7'd0, 7'd1, 7'd127, 7'd65, isfc_pkg::ACTIVE_TAPS_RST};
        foreach (counts[k]) begin
            write_tap_count(counts[k]);
            repeat (3) send_sample(rand_level(1'b0));
        end
    endtask

    // Load part of an impulse response, then stream samples; occasional
    // tap rewrites land mid-stream, and a few zeros push the tail out
    task automatic test_random_streams();
        int start;
        int burst;
        bit wide;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_tap_count(7'd0);
                    1:       write_tap_count(7'd127);
                    2:       write_tap_count(7'd65);
                    3:       write_tap_count(7'd1);
                    4:       write_tap_count(isfc_pkg::ACTIVE_TAPS_RST);
                    default: write_tap_count(CFG_W'($urandom_range(1, TAP_COUNT)));
                endcase
            end
            wide = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 16)) begin
                send_coef(IDX_W'($urandom), rand_level(!wide));
            end
            burst = $urandom_range(10, 60);
            repeat (burst) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_coef(IDX_W'($urandom), rand_level(1'b1));
                end else begin
                    send_sample(rand_level(1'b0));
                end
            end
            repeat ($urandom_range(0, 8)) send_sample(16'sd0);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        taps_in_use = isfc_pkg::ACTIVE_TAPS_RST;
        foreach (tap_coefs[j]) begin
            tap_coefs[j]   = '0;
            partial_acc[j] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_reset_defaults();
        test_impulse_and_rounding();
        test_tap_count_edges();
        test_random_streams();

        // Drain and allow the pipeline to go quiet
        @(negedge aclk) s_valid <= 1'b0;
        for (int k = 0; k < 2000 && expected_outputs.size() != 0; k++) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      expected_outputs.size()));
        end

        $display("Sent %0d sample items and %0d coefficient writes over %0d tap-count settings",
                 n_samples, n_coefs, n_cfg);
        $display("Checked %0d outputs, %0d of them saturated; %0d mismatches",
                 n_results, n_clipped, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/isfc_pkg.sv
rtl/core/isfc_cell.sv
rtl/core/input_side_fir_convolution.sv
rtl/core/isfc_checker.sv
tb/tb.sv
